// ----- hw/rtl/palette_to_mono_dither_macros.svh -----
// Assertion macros for the palette to mono dither block.
`ifndef PALETTE_TO_MONO_DITHER_MACROS_SVH
`define PALETTE_TO_MONO_DITHER_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every edge outside reset.
`define P2MD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define P2MD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define P2MD_ASSERT(label, clk, rst_n, prop, msg)
`define P2MD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/p2md_pkg.sv -----
`default_nettype none

package p2md_pkg;

	localparam int unsigned NUM_COLORS = 4;

	typedef logic [7:0]  luma_t;
	typedef logic [23:0] rgb_t;

	typedef enum logic [2:0] {
		CFG_COLOR_ZERO  = 3'd0,
		CFG_COLOR_ONE   = 3'd1,
		CFG_COLOR_TWO   = 3'd2,
		CFG_COLOR_THREE = 3'd3,
		CFG_DITHER      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] pixel_pair;
		logic        row_odd;
		logic        dither_en;
	} item_t;

	localparam logic [7:0] LUMA_R_COEF = 8'd77;
	localparam logic [7:0] LUMA_G_COEF = 8'd150;
	localparam logic [7:0] LUMA_B_COEF = 8'd29;

	// 2x2 Bayer thresholds, 64*m+32, indexed [row parity][column parity]
	localparam logic [7:0] BAYER_THR [2][2] = '{
		'{8'd32,  8'd160},
		'{8'd224, 8'd96}
	};

	function automatic logic [7:0] bayer_thr(input logic row_odd, input logic col_odd);
		bayer_thr = BAYER_THR[row_odd][col_odd];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/p2md_luma.sv -----
`default_nettype none

module p2md_luma (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid,
	input  wire p2md_pkg::item_t        item,
	input  wire p2md_pkg::rgb_t [3:0]   colors,
	output logic                        valid_s1,
	output p2md_pkg::item_t             item_s1,
	output p2md_pkg::luma_t [3:0]       luma_s1
);

	p2md_pkg::luma_t [3:0] luma;

	always_comb begin
		logic [15:0] sum;
		for (int c = 0; c < 4; c++) begin
			sum = {8'd0, colors[c][23:16]} * {8'd0, p2md_pkg::LUMA_R_COEF}
				+ {8'd0, colors[c][15:8]} * {8'd0, p2md_pkg::LUMA_G_COEF}
				+ {8'd0, colors[c][7:0]} * {8'd0, p2md_pkg::LUMA_B_COEF};
			luma[c] = sum[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		luma_s1 <= luma;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/p2md_sort.sv -----
`default_nettype none

module p2md_sort (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid_s1,
	input  wire p2md_pkg::item_t        item_s1,
	input  wire p2md_pkg::luma_t [3:0]  luma_s1,
	output logic                        valid_s2,
	output p2md_pkg::item_t             item_s2,
	output p2md_pkg::luma_t [3:0]       luma_s2,
	output p2md_pkg::luma_t             lmin_s2,
	output p2md_pkg::luma_t             range_s2,
	output p2md_pkg::luma_t             thr_s2
);

	p2md_pkg::luma_t a0, a1, a2, a3;
	p2md_pkg::luma_t b0, b1, b2, b3;
	p2md_pkg::luma_t m1, m2;
	logic [8:0]      mid_sum;
	p2md_pkg::luma_t span;

	// five compare-exchanges in three levels
	always_comb begin
		a0 = (luma_s1[0] > luma_s1[1]) ? luma_s1[1] : luma_s1[0];
		a1 = (luma_s1[0] > luma_s1[1]) ? luma_s1[0] : luma_s1[1];
		a2 = (luma_s1[2] > luma_s1[3]) ? luma_s1[3] : luma_s1[2];
		a3 = (luma_s1[2] > luma_s1[3]) ? luma_s1[2] : luma_s1[3];
		b0 = (a0 > a2) ? a2 : a0;
		b2 = (a0 > a2) ? a0 : a2;
		b1 = (a1 > a3) ? a3 : a1;
		b3 = (a1 > a3) ? a1 : a3;
		m1 = (b1 > b2) ? b2 : b1;
		m2 = (b1 > b2) ? b1 : b2;
		mid_sum = {1'b0, m1} + {1'b0, m2};
		span = b3 - b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2  <= item_s1;
		luma_s2  <= luma_s1;
		lmin_s2  <= b0;
		range_s2 <= (span == 8'd0) ? 8'd1 : span;
		thr_s2   <= mid_sum[8:1];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/p2md_decide.sv -----
`default_nettype none

module p2md_decide (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid_s2,
	input  wire p2md_pkg::item_t        item_s2,
	input  wire p2md_pkg::luma_t [3:0]  luma_s2,
	input  wire p2md_pkg::luma_t        lmin_s2,
	input  wire p2md_pkg::luma_t        range_s2,
	input  wire p2md_pkg::luma_t        thr_s2,
	output logic                        valid_s3,
	output logic [15:0]                 pixel_pair_s3,
	output logic [3:0][1:0]             black_s3
);

	logic [15:0]     lim [2];
	logic [3:0][1:0] black;

	// floor(x / range) < t  <=>  x < t * range
	always_comb begin
		logic [7:0]  d;
		logic [15:0] x;
		for (int k = 0; k < 2; k++) begin
			lim[k] = {8'd0, p2md_pkg::bayer_thr(item_s2.row_odd, k[0])} * {8'd0, range_s2};
		end
		for (int c = 0; c < 4; c++) begin
			d = luma_s2[c] - lmin_s2;
			x = ({d, 8'd0} - {8'd0, d}) + {9'd0, range_s2[7:1]};
			for (int k = 0; k < 2; k++) begin
				black[c][k] = item_s2.dither_en ? (x < lim[k]) : (luma_s2[c] < thr_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pixel_pair_s3 <= item_s2.pixel_pair;
		black_s3      <= black;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/palette_to_mono_dither.sv -----
// Palette to mono converter: each accepted beat (start high, busy low) carries
// two 2bpp source bytes and the row parity; done pulses for one cycle with
// the matching mono byte once it has passed the four register stages (luma,
// sort, per-color decision, pack). busy stays low, so a beat can enter every
// cycle. Results cannot be stalled. Palette and dither registers are
// written through the cfg port (always ready) and should change only while no
// beat is in flight.
`default_nettype none

`include "palette_to_mono_dither_macros.svh"

module palette_to_mono_dither (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] pixel_pair,
	input  wire logic        row_odd,
	output logic             done,
	output logic [7:0]       mono_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	p2md_pkg::rgb_t [3:0]  colors_q;
	logic                  dither_q;
	logic                  accept;
	p2md_pkg::item_t       item;

	logic                  valid_s1, valid_s2, valid_s3;
	p2md_pkg::item_t       item_s1, item_s2;
	p2md_pkg::luma_t [3:0] luma_s1, luma_s2;
	p2md_pkg::luma_t       lmin_s2, range_s2, thr_s2;
	logic [15:0]           pixel_pair_s3;
	logic [3:0][1:0]       black_s3;
	logic [7:0]            mono;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		item.pixel_pair = pixel_pair;
		item.row_odd    = row_odd;
		item.dither_en  = dither_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q <= '0;
			dither_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				p2md_pkg::CFG_COLOR_ZERO:  colors_q[0] <= cfg_data;
				p2md_pkg::CFG_COLOR_ONE:   colors_q[1] <= cfg_data;
				p2md_pkg::CFG_COLOR_TWO:   colors_q[2] <= cfg_data;
				p2md_pkg::CFG_COLOR_THREE: colors_q[3] <= cfg_data;
				p2md_pkg::CFG_DITHER:      dither_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	p2md_luma u_luma (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (accept),
		.item     (item),
		.colors   (colors_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.luma_s1  (luma_s1)
	);

	p2md_sort u_sort (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.luma_s1  (luma_s1),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.luma_s2  (luma_s2),
		.lmin_s2  (lmin_s2),
		.range_s2 (range_s2),
		.thr_s2   (thr_s2)
	);

	p2md_decide u_decide (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.item_s2       (item_s2),
		.luma_s2       (luma_s2),
		.lmin_s2       (lmin_s2),
		.range_s2      (range_s2),
		.thr_s2        (thr_s2),
		.valid_s3      (valid_s3),
		.pixel_pair_s3 (pixel_pair_s3),
		.black_s3      (black_s3)
	);

	// pixel i from bits 2i+1:2i, lands at bit 7-i; columns alternate even/odd
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mono[7 - i] = black_s3[pixel_pair_s3[2 * i +: 2]][i % 2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		mono_byte <= mono;
	end

	`P2MD_ASSERT(a_latency, clk, arst_n, accept |-> ##4 done, "accepted beat gave no result")
	`P2MD_ASSERT(a_no_phantom, clk, arst_n, done |-> $past(accept, 4), "result without a beat")
	`P2MD_ASSERT_NEXT(a_range_nz, clk, arst_n, valid_s1, range_s2 != 8'd0, "zero luma range")

endmodule

`default_nettype wire

// ----- bench/palette_to_mono_dither_checker.sv -----
module palette_to_mono_dither_checker
	import p2md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] pixel_pair,
	input  logic        row_odd,
	input  logic        done,
	input  logic [7:0]  mono_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);

	rgb_t       palette_rgb [NUM_COLORS];
	logic       dither_on;
	logic [7:0] mono_queue [$];
	logic [7:0] want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] exp_val);
		$display("%0t mismatch: %s got %02h expected %02h", $time, what, got, exp_val);
		errors++;
	endtask

	function automatic int unsigned brightness(input rgb_t rgb);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		r = 32'(rgb[23:16]);
		g = 32'(rgb[15:8]);
		b = 32'(rgb[7:0]);
		return ((r * 77 + g * 150 + b * 29) >> 8) & 8'hFF;
	endfunction

	function automatic logic [7:0] mono_of(input logic [15:0] pair, input logic row);
		int unsigned lum [NUM_COLORS];
		int unsigned srt [NUM_COLORS];
		int unsigned tmp;
		int unsigned mid;
		int unsigned span;
		int unsigned norm;
		int unsigned thr;
		int unsigned l;
		logic [7:0]  res;
		res = '0;
		for (int i = 0; i < NUM_COLORS; i++) begin
			lum[i] = brightness(palette_rgb[i]);
			srt[i] = lum[i];
		end
		for (int i = 0; i < NUM_COLORS - 1; i++)
			for (int j = i + 1; j < NUM_COLORS; j++)
				if (srt[i] > srt[j]) begin
					tmp    = srt[i];
					srt[i] = srt[j];
					srt[j] = tmp;
				end
		mid  = (srt[1] + srt[2]) / 2;
		span = srt[3] - srt[0];
		if (span == 0)
			span = 1;
		for (int p = 0; p < 8; p++) begin
			l = lum[pair[2*p +: 2]];
			if (dither_on) begin
				norm = ((l - srt[0]) * 255 + span / 2) / span;
				// 2x2 ordered matrix [[0,2],[3,1]] scaled by 64, offset 32
				if (row)
					thr = ((p % 2) ? 1 : 3) * 64 + 32;
				else
					thr = ((p % 2) ? 2 : 0) * 64 + 32;
				res[7-p] = norm < thr;
			end else begin
				res[7-p] = l < mid;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COLORS; i++)
				palette_rgb[i] <= '0;
			dither_on <= 1'b0;
			mono_queue.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_COLOR_ZERO, CFG_COLOR_ONE, CFG_COLOR_TWO, CFG_COLOR_THREE:
						palette_rgb[cfg_index[1:0]] <= cfg_data;
					CFG_DITHER: dither_on <= cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				mono_queue.push_back(mono_of(pixel_pair, row_odd));
			if (done) begin
				if (mono_queue.size() == 0) begin
					report_mismatch("unexpected beat mono_byte", mono_byte, 8'h00);
				end else begin
					want = mono_queue.pop_front();
					if (mono_byte !== want)
						report_mismatch("mono_byte", mono_byte, want);
				end
			end
			pending <= mono_queue.size();
		end
	end

endmodule

// ----- bench/tb_palette_to_mono_dither.sv -----
module tb_palette_to_mono_dither;
	import p2md_pkg::*;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [15:0] pixel_pair = '0;
	logic        row_odd    = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [23:0] cfg_data   = '0;
	logic        busy;
	logic        done;
	logic [7:0]  mono_byte;
	logic        cfg_ready;
	int          errors;
	int          pending;
	int          idle_pct;

	palette_to_mono_dither dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_pair (pixel_pair),
		.row_odd    (row_odd),
		.done       (done),
		.mono_byte  (mono_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	palette_to_mono_dither_checker mono_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_pair (pixel_pair),
		.row_odd    (row_odd),
		.done       (done),
		.mono_byte  (mono_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	initial begin
		#4000000;
		$display("palette_to_mono_dither regression: fail");
		$finish;
	end

	task automatic send_pixels(input logic [15:0] pair, input logic row);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		pixel_pair <= pair;
		row_odd    <= row;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_palette(input rgb_t c0, input rgb_t c1, input rgb_t c2,
		input rgb_t c3, input logic dith);
		write_reg(CFG_COLOR_ZERO, c0);
		write_reg(CFG_COLOR_ONE, c1);
		write_reg(CFG_COLOR_TWO, c2);
		write_reg(CFG_COLOR_THREE, c3);
		// upper data bits must be ignored by the one-bit register
		write_reg(CFG_DITHER, {23'($urandom), dith});
		// index past the register list, must be dropped
		write_reg(3'(CFG_DITHER) + 3'($urandom_range(3, 1)), 24'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic rgb_t pick_color();
		case ($urandom_range(4))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return 24'hFF << (8 * $urandom_range(2));
			3: return 24'(24'h010101 * $urandom_range(255));
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] corner [6];
		rgb_t        c [4];
		corner = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hE4E4, 16'h1B1B};
		idle_pct = 38;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset palette: all colors equal
		send_pixels(16'h0000, 1'b0);
		send_pixels(16'hFFFF, 1'b1);
		send_pixels(16'hE4E4, 1'b0);
		send_pixels(16'h1B1B, 1'b1);
		drain_results();
		load_palette(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
		for (int i = 0; i < 4; i++)
			send_pixels(corner[i+2], i[0]);
		drain_results();
		load_palette(24'h000000, 24'h555555, 24'hAAAAAA, 24'hFFFFFF, 1'b0);
		for (int i = 0; i < 6; i++)
			send_pixels(corner[i], i[0]);
		drain_results();
		load_palette(24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'h000000, 1'b1);
		for (int i = 0; i < 8; i++)
			send_pixels(corner[i % 6], i[0]);
		drain_results();

		for (int ph = 0; ph < 16; ph++) begin
			idle_pct = (ph < 6) ? 38 : (ph < 11) ? 85 : 0;
			for (int i = 0; i < 4; i++)
				c[i] = pick_color();
			case ($urandom_range(5))
				0: begin
					c[1] = c[0];
					c[2] = c[0];
					c[3] = c[0];
				end
				1: c[2] = c[1];
				default: ;
			endcase
			if (ph == 0) begin
				c = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
			end else if (ph == 1) begin
				c = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF};
			end
			load_palette(c[0], c[1], c[2], c[3], 1'($urandom));
			repeat (100)
				send_pixels(16'($urandom), 1'($urandom));
			drain_results();
		end

		if (errors == 0 && pending == 0)
			$display("palette_to_mono_dither regression: pass");
		else
			$display("palette_to_mono_dither regression: fail");
		$finish;
	end

endmodule
